/* rtl/bzgb_pkg.sv */
// ----------------------------------------------------------------------------
// bzgb_pkg
// Shared widths, fixed-point constants and types for the buffer zone blend.
// ----------------------------------------------------------------------------
package bzgb_pkg;

   // field widths
   localparam int DIST_W   = 24;             // Q8.16 distance / radius
   localparam int GRAD_W   = 32;             // signed Q16.16 gradient
   localparam int INV_W    = 32;             // Q16.16 reciprocal
   localparam int MODE_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int Q_FRAC   = 16;

   // weight path widths
   localparam int W_W      = Q_FRAC + 1;     // Q1.16, up to 1.0
   localparam int PROD_W   = DIST_W + INV_W;
   localparam int TFULL_W  = PROD_W - Q_FRAC;
   localparam int K3_W     = W_W + 1;        // 3 - 2t, up to 3.0
   localparam int K10_W    = W_W + 3;        // 15 - 6t and 10 - x, up to 15.0
   localparam int WSS_W    = W_W + K3_W - Q_FRAC;
   localparam int WSM_W    = W_W + K10_W - Q_FRAC;

   // mix path widths
   localparam int PRD_W    = W_W + 1 + GRAD_W;
   localparam int SUM_W    = PRD_W + 1;
   localparam int SH_W     = SUM_W - Q_FRAC;

   // pipeline shape
   localparam int PIPE_DEPTH = 8;            // stage 0 .. output register
   localparam int MIX_TAP    = 5;            // stage at which the weight is ready
   localparam int NUM_AXES   = 3;

   // fixed-point constants
   localparam logic [W_W-1:0]   ONE_Q16   = W_W'(1 << Q_FRAC);
   localparam logic [K3_W-1:0]  K3_BASE   = K3_W'(3 << Q_FRAC);
   localparam logic [K10_W-1:0] K15_BASE  = K10_W'(15 << Q_FRAC);
   localparam logic [K10_W-1:0] K10_BASE  = K10_W'(10 << Q_FRAC);
   localparam logic [K10_W-1:0] K6_COEF   = K10_W'(6);

   typedef enum logic [MODE_W-1:0] {
      MODE_LINEAR   = 2'd0,
      MODE_SMOOTH   = 2'd1,
      MODE_SMOOTHER = 2'd2
   } blend_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INNER     = 2'd0,
      CSR_OUTER     = 2'd1,
      CSR_INV_WIDTH = 2'd2,
      CSR_MODE      = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [INV_W-1:0] inv_width;
      blend_mode_type   mode;
   } weight_cfg_type;

endpackage

/* rtl/bzgb_weight.sv */
// ----------------------------------------------------------------------------
// bzgb_weight
// Five-stage weight pipeline: t from span and reciprocal, then shape.
// ----------------------------------------------------------------------------
module bzgb_weight import bzgb_pkg::*; (
   input  logic                 clock,
   input  logic                 advance,
   input  weight_cfg_type       cfg,
   input  logic [DIST_W-1:0]    span,
   output logic [W_W-1:0]       weight
);

   // stage A: raw product
   logic [PROD_W-1:0]  prod_in, prod_ff;
   // stage B: clamped t and linear factors
   logic [TFULL_W-1:0] tfull;
   logic [W_W-1:0]     tb_in, tb_ff;
   logic [K3_W-1:0]    k3b_in, k3b_ff;
   logic [K10_W-1:0]   k10b_in, k10b_ff;
   // stage C: t squared and t times (15 - 6t)
   logic [2*W_W-1:0]   tt;
   logic [W_W+K10_W-1:0] tk;
   logic [W_W-1:0]     t2c_in, t2c_ff, tc_ff;
   logic [K10_W-1:0]   mc_in, mc_ff;
   logic [K3_W-1:0]    k3c_ff;
   // stage D: smoothstep weight, cube and smootherstep factor
   logic [W_W+K3_W-1:0] ss;
   logic [2*W_W-1:0]   t3p;
   logic [WSS_W-1:0]   wssd_in, wssd_ff;
   logic [W_W-1:0]     t3d_in, t3d_ff, td_ff;
   logic [K10_W-1:0]   ad_in, ad_ff;
   // stage E: select and clamp
   logic [W_W+K10_W-1:0] sm;
   logic [WSM_W-1:0]   wsel;
   logic [W_W-1:0]     w_in, w_ff;

   assign prod_in = PROD_W'(span) * PROD_W'(cfg.inv_width);

   assign tfull   = prod_ff[PROD_W-1:Q_FRAC];
   assign tb_in   = (tfull > TFULL_W'(ONE_Q16)) ? ONE_Q16 : tfull[W_W-1:0];
   assign k3b_in  = K3_BASE - (K3_W'(tb_in) << 1);
   assign k10b_in = K15_BASE - K10_W'(K10_W'(tb_in) * K6_COEF);

   assign tt      = (2*W_W)'(tb_ff) * (2*W_W)'(tb_ff);
   assign tk      = (W_W+K10_W)'(tb_ff) * (W_W+K10_W)'(k10b_ff);
   assign t2c_in  = tt[Q_FRAC+W_W-1:Q_FRAC];
   assign mc_in   = tk[Q_FRAC+K10_W-1:Q_FRAC];

   assign ss      = (W_W+K3_W)'(t2c_ff) * (W_W+K3_W)'(k3c_ff);
   assign t3p     = (2*W_W)'(t2c_ff) * (2*W_W)'(tc_ff);
   assign wssd_in = ss[W_W+K3_W-1:Q_FRAC];
   assign t3d_in  = t3p[Q_FRAC+W_W-1:Q_FRAC];
   assign ad_in   = K10_BASE - mc_ff;

   assign sm = (W_W+K10_W)'(t3d_ff) * (W_W+K10_W)'(ad_ff);

   always_comb begin
      unique case (cfg.mode)
         MODE_SMOOTH:   wsel = WSM_W'(wssd_ff);
         MODE_SMOOTHER: wsel = sm[W_W+K10_W-1:Q_FRAC];
         default:       wsel = WSM_W'(td_ff);
      endcase
   end

   assign w_in = (wsel > WSM_W'(ONE_Q16)) ? ONE_Q16 : wsel[W_W-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         tb_ff   <= tb_in;
         k3b_ff  <= k3b_in;
         k10b_ff <= k10b_in;
         t2c_ff  <= t2c_in;
         mc_ff   <= mc_in;
         tc_ff   <= tb_ff;
         k3c_ff  <= k3b_ff;
         wssd_ff <= wssd_in;
         t3d_ff  <= t3d_in;
         ad_ff   <= ad_in;
         td_ff   <= tc_ff;
         w_ff    <= w_in;
      end
   end

   assign weight = w_ff;

endmodule

/* rtl/bzgb_mix.sv */
// ----------------------------------------------------------------------------
// bzgb_mix
// Two-stage blend of one component: products, then floor shift and saturate; unblended words pass the gradient.
// ----------------------------------------------------------------------------
module bzgb_mix import bzgb_pkg::*; (
   input  logic                     clock,
   input  logic                     advance,
   input  logic [W_W-1:0]           weight,
   input  logic                     blend,
   input  logic signed [GRAD_W-1:0] grad,
   input  logic signed [GRAD_W-1:0] guess,
   output logic signed [GRAD_W-1:0] result
);

   logic [W_W-1:0]            wc;
   logic signed [PRD_W-1:0]   pg_in, pg_ff, pq_in, pq_ff;
   logic signed [GRAD_W-1:0]  grad_ff;
   logic                      blend_ff;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SH_W-1:0]    sh;
   logic [SH_W-GRAD_W:0]      hi;
   logic signed [GRAD_W-1:0]  sat, result_in, result_ff;

   assign wc    = ONE_Q16 - weight;
   assign pg_in = PRD_W'($signed({1'b0, weight})) * PRD_W'(grad);
   assign pq_in = PRD_W'($signed({1'b0, wc})) * PRD_W'(guess);

   // arithmetic shift of the sum is the floor of the quotient
   assign sum = SUM_W'(pg_ff) + SUM_W'(pq_ff);
   assign sh  = sum[SUM_W-1:Q_FRAC];
   assign hi  = sh[SH_W-1:GRAD_W-1];

   always_comb begin
      if (&hi || ~|hi) begin
         sat = sh[GRAD_W-1:0];
      end else if (sh[SH_W-1]) begin
         sat = {1'b1, {(GRAD_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(GRAD_W-1){1'b1}}};
      end
   end

   assign result_in = blend_ff ? sat : grad_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         pg_ff     <= pg_in;
         pq_ff     <= pq_in;
         grad_ff   <= grad;
         blend_ff  <= blend;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* rtl/buffer_zone_gradient_blend_top.sv */
// Path: each accepted request word runs through stage 0, the weight and mix stages, to the output register.
// Throughput: one word per cycle; the whole pipeline holds while rsp_stall is
//    high on a valid result, and only then is req_stall raised.
// Reset: synchronous, active high; clears all stage valid bits and sets every
//    configuration register to zero. csr writes are always taken (csr_ready high).
// ----------------------------------------------------------------------------
// buffer_zone_gradient_blend_top
// Linear, smoothstep or smootherstep blend of computed and guessed gradients for
// buffer shell atoms with all grad components nonzero; others pass the computed one.
// ----------------------------------------------------------------------------
module buffer_zone_gradient_blend_top import bzgb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [DIST_W-1:0]         req_distance,
   input  logic signed [GRAD_W-1:0]  req_grad_x,
   input  logic signed [GRAD_W-1:0]  req_grad_y,
   input  logic signed [GRAD_W-1:0]  req_grad_z,
   input  logic signed [GRAD_W-1:0]  req_guess_x,
   input  logic signed [GRAD_W-1:0]  req_guess_y,
   input  logic signed [GRAD_W-1:0]  req_guess_z,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_in_shell,
   output logic                      rsp_blended,
   output logic signed [GRAD_W-1:0]  rsp_out_x,
   output logic signed [GRAD_W-1:0]  rsp_out_y,
   output logic signed [GRAD_W-1:0]  rsp_out_z,
   // configuration write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [DIST_W-1:0] inner_ff;
   logic [DIST_W-1:0] outer_ff;
   logic [INV_W-1:0]  inv_width_ff;
   blend_mode_type    mode_ff;
   weight_cfg_type    wcfg;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff     <= '0;
         outer_ff     <= '0;
         inv_width_ff <= '0;
         mode_ff      <= MODE_LINEAR;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_INNER:     inner_ff     <= csr_data[DIST_W-1:0];
            CSR_OUTER:     outer_ff     <= csr_data[DIST_W-1:0];
            CSR_INV_WIDTH: inv_width_ff <= csr_data[INV_W-1:0];
            CSR_MODE:      mode_ff      <= blend_mode_type'(csr_data[MODE_W-1:0]);
            default:       ;
         endcase
      end
   end

   assign wcfg.inv_width = inv_width_ff;
   assign wcfg.mode      = mode_ff;

   // ---------------------------------------------------------------------
   // Pipeline control: every stage advances together unless the output
   // word is valid and held by the receiver.
   // ---------------------------------------------------------------------
   logic advance;
   logic accept;
   logic vld_ff   [PIPE_DEPTH];
   logic shell_ff [PIPE_DEPTH];
   logic blend_ff [PIPE_DEPTH];

   assign advance   = !(vld_ff[PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // ---------------------------------------------------------------------
   // Stage 0: shell test, nonzero test, span to outer radius
   // ---------------------------------------------------------------------
   logic              shell_in;
   logic              blend_in;
   logic [DIST_W-1:0] span_in, span_ff;

   assign shell_in = (req_distance > inner_ff) && (req_distance <= outer_ff);
   assign blend_in = shell_in && (|req_grad_x) && (|req_grad_y) && (|req_grad_z);
   // span only matters for blended atoms, where it never wraps
   assign span_in  = outer_ff - req_distance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= accept;
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // flags ride alongside the valid bits to the output register
   always_ff @(posedge clock) begin
      if (advance) begin
         shell_ff[0] <= shell_in;
         blend_ff[0] <= blend_in;
         span_ff     <= span_in;
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            shell_ff[i] <= shell_ff[i-1];
            blend_ff[i] <= blend_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Gradient and guess delay lines, stage 0 through the mix tap
   // ---------------------------------------------------------------------
   logic signed [GRAD_W-1:0] grad_ff  [MIX_TAP+1][NUM_AXES];
   logic signed [GRAD_W-1:0] guess_ff [MIX_TAP+1][NUM_AXES];
   logic signed [GRAD_W-1:0] result   [NUM_AXES];

   always_ff @(posedge clock) begin
      if (advance) begin
         grad_ff[0][0]  <= req_grad_x;
         grad_ff[0][1]  <= req_grad_y;
         grad_ff[0][2]  <= req_grad_z;
         guess_ff[0][0] <= req_guess_x;
         guess_ff[0][1] <= req_guess_y;
         guess_ff[0][2] <= req_guess_z;
         for (int s = 1; s <= MIX_TAP; s++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               grad_ff[s][a]  <= grad_ff[s-1][a];
               guess_ff[s][a] <= guess_ff[s-1][a];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stages 1-5: weight; stages 6-7: per-axis blend and output register
   // ---------------------------------------------------------------------
   logic [W_W-1:0] weight;

   bzgb_weight u_weight (
      .clock   (clock),
      .advance (advance),
      .cfg     (wcfg),
      .span    (span_ff),
      .weight  (weight)
   );

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      bzgb_mix u_mix (
         .clock   (clock),
         .advance (advance),
         .weight  (weight),
         .blend   (blend_ff[MIX_TAP]),
         .grad    (grad_ff[MIX_TAP][a]),
         .guess   (guess_ff[MIX_TAP][a]),
         .result  (result[a])
      );
   end

   assign rsp_valid    = vld_ff[PIPE_DEPTH-1];
   assign rsp_in_shell = shell_ff[PIPE_DEPTH-1];
   assign rsp_blended  = blend_ff[PIPE_DEPTH-1];
   assign rsp_out_x    = result[0];
   assign rsp_out_y    = result[1];
   assign rsp_out_z    = result[2];

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_blend_needs_shell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_blended || rsp_in_shell))
      else $error("blended word outside the buffer shell");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[MIX_TAP] |-> (weight <= ONE_Q16))
      else $error("blend weight above one");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held response");

endmodule
